### src/cbz_pkg.sv
`timescale 1ns / 1ps

package cbz_pkg;

  // Coordinate and parameter formats
  localparam int CW   = 21;            // signed Q10.10 coordinate
  localparam int TF   = 16;            // fraction bits of t
  localparam int TW   = TF + 1;        // t, u and their products
  localparam int WW   = TW + 1;        // Bernstein weights (3x fits)
  localparam int KW   = TW + 2;        // derivative coefficients (6x fits)
  localparam int PW   = WW + 1 + CW + 2; // position sum
  localparam int DW   = KW + 1 + CW + 1 + 2; // derivative sum
  localparam int MW   = DW - 1;        // derivative magnitude
  localparam int SW   = 6;             // msb index of a magnitude
  localparam int NW   = 30;            // normalized magnitude, below 2^30
  localparam int QW   = 2 * NW + 2;    // sum of squares
  localparam int LW   = QW / 2;        // tangent length
  localparam int UB   = 20;            // unit vector fraction bits
  localparam int RW   = NW + UB + 1;   // divider remainder
  localparam int QTW  = UB + 1;        // unit magnitude, at most 2^20
  localparam int XW   = CW + QTW + 1;  // cross product term
  localparam int REGW = 3 * CW;        // packed x,y,z register
  localparam int IW   = 3;             // config index

  localparam logic [TW-1:0] T_ONE = TW'(1) << TF;

  localparam logic [IW-1:0] REG_START_POINT  = 3'd0;
  localparam logic [IW-1:0] REG_END_POINT    = 3'd1;
  localparam logic [IW-1:0] REG_START_HANDLE = 3'd2;
  localparam logic [IW-1:0] REG_END_HANDLE   = 3'd3;
  localparam logic [IW-1:0] REG_SURF_NORMAL  = 3'd4;
  localparam logic [IW-1:0] REG_PERP_EN      = 3'd5;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] deriv_t;

  typedef struct packed {
    coord_t     pos_x;
    coord_t     pos_y;
    coord_t     pos_z;
    logic       deg;
    logic [2:0] sgn;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [2:0][NW-1:0]  mag;
  } sq_pay_t;

  function automatic coord_t coord(input logic [REGW-1:0] r, input int i);
    return r[i*CW +: CW];
  endfunction

  function automatic coord_t sat_coord(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    hi = (DW'(1) <<< (CW-1)) - DW'(1);
    lo = -hi - DW'(1);
    if (v > hi) return hi[CW-1:0];
    else if (v < lo) return lo[CW-1:0];
    else return v[CW-1:0];
  endfunction

endpackage

### src/cbz_eval.sv
`timescale 1ns / 1ps

// Bernstein weights, position and exact first derivative: five stages.
module cbz_eval (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [cbz_pkg::TW-1:0]     in_t,
  input  logic [cbz_pkg::REGW-1:0]   p0,   // start point
  input  logic [cbz_pkg::REGW-1:0]   p1,   // start handle
  input  logic [cbz_pkg::REGW-1:0]   p2,   // end handle
  input  logic [cbz_pkg::REGW-1:0]   p3,   // end point
  output logic                       out_valid,
  output cbz_pkg::coord_t            out_pos [3],
  output cbz_pkg::deriv_t            out_d [3]
);
  import cbz_pkg::*;

  function automatic logic [TW-1:0] rmul(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [2*TW-1:0] p;
    p = a * b + ((2*TW)'(1) << (TF-1));
    return p[TF+TW-1:TF];
  endfunction

  logic                 v_r [5];
  logic [TW-1:0]        t1_r, u1_r;
  logic [TW-1:0]        t2_r, u2_r, ut_r, t2c_r, u2c_r;
  logic [WW-1:0]        w_r [4];
  logic [KW-1:0]        k_r [3];
  logic signed [PW-1:0] pp_r [3][4];
  deriv_t               dp_r [3][3];
  coord_t               pos_r [3];
  deriv_t               d_r [3];

  logic [TW-1:0]        tc;
  coord_t               pc [4][3];
  logic signed [CW:0]   df [3][3];
  logic signed [WW:0]   ws [4];
  logic signed [KW:0]   ks [3];

  always_comb begin
    tc = (in_t > T_ONE) ? T_ONE : in_t;
    for (int i = 0; i < 3; i++) begin
      pc[0][i] = coord(p0, i);
      pc[1][i] = coord(p1, i);
      pc[2][i] = coord(p2, i);
      pc[3][i] = coord(p3, i);
      for (int j = 0; j < 3; j++) begin
        df[i][j] = {pc[j+1][i][CW-1], pc[j+1][i]} - {pc[j][i][CW-1], pc[j][i]};
      end
    end
    for (int j = 0; j < 4; j++) ws[j] = {1'b0, w_r[j]};
    for (int j = 0; j < 3; j++) ks[j] = {1'b0, k_r[j]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 5; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int s = 1; s < 5; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // clamp t, form u = 1 - t
      t1_r <= tc;
      u1_r <= T_ONE - tc;
      // quadratic terms
      t2_r  <= rmul(t1_r, t1_r);
      u2_r  <= rmul(u1_r, u1_r);
      ut_r  <= rmul(u1_r, t1_r);
      t2c_r <= t1_r;
      u2c_r <= u1_r;
      // cubic weights and derivative coefficients
      w_r[0] <= WW'(rmul(u2_r, u2c_r));
      w_r[1] <= WW'(rmul(u2_r, t2c_r)) * WW'(3);
      w_r[2] <= WW'(rmul(t2_r, u2c_r)) * WW'(3);
      w_r[3] <= WW'(rmul(t2_r, t2c_r));
      k_r[0] <= KW'(u2_r) * KW'(3);
      k_r[1] <= KW'(ut_r) * KW'(6);
      k_r[2] <= KW'(t2_r) * KW'(3);
      // products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) pp_r[i][j] <= ws[j] * pc[j][i];
        for (int j = 0; j < 3; j++) dp_r[i][j] <= ks[j] * df[i][j];
      end
      // sums, rounding, saturation
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= sat_coord(DW'((pp_r[i][0] + pp_r[i][1] + pp_r[i][2] + pp_r[i][3]
                                   + (PW'(1) <<< (TF-1))) >>> TF));
        d_r[i]   <= dp_r[i][0] + dp_r[i][1] + dp_r[i][2];
      end
    end
  end

  assign out_valid = v_r[4];
  assign out_pos   = pos_r;
  assign out_d     = d_r;

endmodule

### src/cbz_sqrt.sv
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one result bit per stage.
module cbz_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [cbz_pkg::QW-1:0] in_val,
  input  cbz_pkg::sq_pay_t       in_pay,
  output logic                   out_valid,
  output logic [cbz_pkg::LW-1:0] out_root,
  output cbz_pkg::sq_pay_t       out_pay
);
  import cbz_pkg::*;

  logic          v_r    [LW];
  logic [QW-1:0] rem_r  [LW];
  logic [LW-1:0] root_r [LW];
  sq_pay_t       pay_r  [LW];

  genvar k;
  for (k = 0; k < LW; k++) begin : g_stage
    localparam int B = LW - 1 - k;
    logic          vin;
    logic [QW-1:0] rem_in;
    logic [LW-1:0] root_in;
    sq_pay_t       pay_in;
    logic [QW:0]   inc;

    if (k == 0) begin : g_first
      assign vin     = in_valid;
      assign rem_in  = in_val;
      assign root_in = '0;
      assign pay_in  = in_pay;
    end else begin : g_next
      assign vin     = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign pay_in  = pay_r[k-1];
    end

    // (r + 2^B)^2 - r^2
    assign inc = ((QW+1)'(root_in) << (B+1)) + ((QW+1)'(1) << (2*B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= inc) begin
          rem_r[k]  <= QW'({1'b0, rem_in} - inc);
          root_r[k] <= root_in | (LW'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
        pay_r[k] <= pay_in;
      end
    end
  end

  assign out_valid = v_r[LW-1];
  assign out_root  = root_r[LW-1];
  assign out_pay   = pay_r[LW-1];

endmodule

### src/cbz_div.sv
`timescale 1ns / 1ps

// Three-lane restoring divider, rounded quotient of mag * 2^20 by len.
module cbz_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [cbz_pkg::LW-1:0]  in_len,
  input  cbz_pkg::sq_pay_t        in_pay,
  output logic                    out_valid,
  output logic [cbz_pkg::QTW-1:0] out_q [3],
  output cbz_pkg::side_t          out_side
);
  import cbz_pkg::*;

  logic           v_r    [QTW];
  logic [LW-1:0]  len_r  [QTW];
  logic [RW-1:0]  rem_r  [QTW][3];
  logic [QTW-1:0] q_r    [QTW][3];
  side_t          side_r [QTW];

  genvar k;
  for (k = 0; k < QTW; k++) begin : g_stage
    localparam int B = QTW - 1 - k;
    logic           vin;
    logic [LW-1:0]  len_in;
    logic [RW-1:0]  rem_in [3];
    logic [QTW-1:0] q_in [3];
    side_t          side_in;
    logic [RW-1:0]  den;

    if (k == 0) begin : g_first
      always_comb begin
        vin     = in_valid;
        len_in  = in_len;
        side_in = in_pay.side;
        for (int j = 0; j < 3; j++) begin
          rem_in[j] = (RW'(in_pay.mag[j]) << UB) + RW'(in_len >> 1);
          q_in[j]   = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vin     = v_r[k-1];
        len_in  = len_r[k-1];
        side_in = side_r[k-1];
        for (int j = 0; j < 3; j++) begin
          rem_in[j] = rem_r[k-1][j];
          q_in[j]   = q_r[k-1][j];
        end
      end
    end

    assign den = RW'(len_in) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[k]  <= len_in;
        side_r[k] <= side_in;
        for (int j = 0; j < 3; j++) begin
          if (rem_in[j] >= den) begin
            rem_r[k][j] <= rem_in[j] - den;
            q_r[k][j]   <= q_in[j] | (QTW'(1) << B);
          end else begin
            rem_r[k][j] <= rem_in[j];
            q_r[k][j]   <= q_in[j];
          end
        end
      end
    end
  end

  assign out_valid = v_r[QTW-1];
  assign out_side  = side_r[QTW-1];
  always_comb begin
    for (int j = 0; j < 3; j++) out_q[j] = q_r[QTW-1][j];
  end

endmodule

### src/cubic_bezier_point_and_normal.sv
`timescale 1ns / 1ps

// Cubic Bezier evaluator. Each t (Q1.16, values above one clamp to one) gives
// the curve position from the four control points and, with perp_enable set,
// the surface normal crossed with the unit tangent (normal x tangent order),
// all as saturated signed Q10.10. A zero tangent raises degenerate and zeroes
// the perpendicular; with perp_enable clear both are zero. The pipeline takes
// one transfer per clock and returns one result per t; its stages are 5 of
// weights, position and derivative, 5 of tangent normalization and squaring,
// 31 of the one-bit-per-stage square root, 21 of the restoring divider that
// forms the unit tangent, and 2 of cross product and output register. A
// stalled output holds the whole pipeline. Control points are written through
// the cfg channel (index 0 start_point, 1 end_point, 2 start_handle, 3
// end_handle, 4 surface_normal, 5 perp_enable) by the user only while no item
// is in flight, which the block leaves unenforced; other indexes are dropped.
module cubic_bezier_point_and_normal (
  input  logic                         clk,
  input  logic                         rst_n,
  // t in bits 16:0
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,
  // pos_x, pos_y, pos_z, perp_x, perp_y, perp_z from bit 0, 21 bits each
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [127:0]                 out_tdata,
  // degenerate
  output logic                         out_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cbz_pkg::IW-1:0]       cfg_index,
  input  logic [cbz_pkg::REGW-1:0]     cfg_data
);
  import cbz_pkg::*;

  // configuration
  logic [REGW-1:0] start_point_r, end_point_r, start_handle_r, end_handle_r, normal_r;
  logic            perp_en_r;

  logic en;

  // eval outputs
  logic   ev_valid;
  coord_t ev_pos [3];
  deriv_t ev_d [3];

  // normalization stages
  logic            v6_r, v7_r, v8_r, v9_r, v10_r;
  side_t           side6_r, side7_r, side8_r, side9_r, side10_r;
  logic [MW-1:0]   mag6_r [3];
  logic [MW-1:0]   max6_r;
  logic [MW-1:0]   mag7_r [3];
  logic [SW-1:0]   msb7_r;
  logic [NW-1:0]   nm8_r [3];
  logic [NW-1:0]   nm9_r [3];
  logic [2*NW-1:0] sq9_r [3];
  logic [NW-1:0]   nm10_r [3];
  logic [QW-1:0]   ssum10_r;

  // square root and divider
  sq_pay_t         sq_in;
  logic            sq_valid;
  logic [LW-1:0]   sq_len;
  sq_pay_t         sq_pay;
  logic            dv_valid;
  logic [QTW-1:0]  dv_q [3];
  side_t           dv_side;

  // cross product and output
  logic                 vx_r;
  side_t                sidex_r;
  logic signed [XW-1:0] cp_r [6];
  logic                 out_v_r;
  coord_t               pos_o_r [3];
  coord_t               perp_o_r [3];
  logic                 deg_o_r;

  // comb helpers
  logic [DW-1:0]        absd [3];
  logic [MW-1:0]        mag6_nxt [3];
  logic [MW-1:0]        max6_nxt;
  logic [SW-1:0]        msb7_nxt;
  logic [MW+NW-2:0]     ext [3];
  logic signed [QTW:0]  un [3];
  coord_t               nv [3];
  deriv_t               px [3];
  coord_t               perp_nxt [3];

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_point_r  <= '0;
      end_point_r    <= '0;
      start_handle_r <= '0;
      end_handle_r   <= '0;
      normal_r       <= '0;
      perp_en_r      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_POINT:  start_point_r  <= cfg_data;
        REG_END_POINT:    end_point_r    <= cfg_data;
        REG_START_HANDLE: start_handle_r <= cfg_data;
        REG_END_HANDLE:   end_handle_r   <= cfg_data;
        REG_SURF_NORMAL:  normal_r       <= cfg_data;
        REG_PERP_EN:      perp_en_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cbz_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_t      (in_tdata[TW-1:0]),
    .p0        (start_point_r),
    .p1        (start_handle_r),
    .p2        (end_handle_r),
    .p3        (end_point_r),
    .out_valid (ev_valid),
    .out_pos   (ev_pos),
    .out_d     (ev_d)
  );

  // |d|, its largest component, msb position and normalizing shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absd[i]     = ev_d[i][DW-1] ? DW'(-ev_d[i]) : DW'(ev_d[i]);
      mag6_nxt[i] = absd[i][MW-1:0];
    end
    max6_nxt = mag6_nxt[0];
    if (mag6_nxt[1] > max6_nxt) max6_nxt = mag6_nxt[1];
    if (mag6_nxt[2] > max6_nxt) max6_nxt = mag6_nxt[2];
    msb7_nxt = '0;
    for (int i = 0; i < MW; i++) begin
      if (max6_r[i]) msb7_nxt = SW'(i);
    end
    // place msb at bit NW-1: shifts left below it, truncates above it
    for (int i = 0; i < 3; i++) begin
      ext[i] = {mag7_r[i], {(NW-1){1'b0}}} >> msb7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (en) begin
      v6_r  <= ev_valid;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side6_r.pos_x <= ev_pos[0];
      side6_r.pos_y <= ev_pos[1];
      side6_r.pos_z <= ev_pos[2];
      side6_r.deg   <= (ev_d[0] == '0) && (ev_d[1] == '0) && (ev_d[2] == '0);
      side6_r.sgn   <= {ev_d[2][DW-1], ev_d[1][DW-1], ev_d[0][DW-1]};
      mag6_r        <= mag6_nxt;
      max6_r        <= max6_nxt;

      side7_r <= side6_r;
      mag7_r  <= mag6_r;
      msb7_r  <= msb7_nxt;

      side8_r <= side7_r;
      for (int i = 0; i < 3; i++) nm8_r[i] <= ext[i][NW-1:0];

      side9_r <= side8_r;
      nm9_r   <= nm8_r;
      for (int i = 0; i < 3; i++) sq9_r[i] <= nm8_r[i] * nm8_r[i];

      side10_r <= side9_r;
      nm10_r   <= nm9_r;
      ssum10_r <= QW'(sq9_r[0]) + QW'(sq9_r[1]) + QW'(sq9_r[2]);
    end
  end

  always_comb begin
    sq_in.side = side10_r;
    for (int i = 0; i < 3; i++) sq_in.mag[i] = nm10_r[i];
  end

  cbz_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v10_r),
    .in_val    (ssum10_r),
    .in_pay    (sq_in),
    .out_valid (sq_valid),
    .out_root  (sq_len),
    .out_pay   (sq_pay)
  );

  cbz_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_len    (sq_len),
    .in_pay    (sq_pay),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // signed unit tangent, normal x unit, round and clamp
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      un[i] = dv_side.sgn[i] ? -$signed({1'b0, dv_q[i]}) : $signed({1'b0, dv_q[i]});
      nv[i] = coord(normal_r, i);
    end
    for (int i = 0; i < 3; i++) begin
      px[i] = DW'(cp_r[2*i]) - DW'(cp_r[2*i+1]) + (DW'(1) <<< (UB-1));
      perp_nxt[i] = sat_coord(px[i] >>> UB);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vx_r    <= dv_valid;
      out_v_r <= vx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sidex_r <= dv_side;
      cp_r[0] <= nv[1] * un[2];
      cp_r[1] <= nv[2] * un[1];
      cp_r[2] <= nv[2] * un[0];
      cp_r[3] <= nv[0] * un[2];
      cp_r[4] <= nv[0] * un[1];
      cp_r[5] <= nv[1] * un[0];

      pos_o_r[0] <= sidex_r.pos_x;
      pos_o_r[1] <= sidex_r.pos_y;
      pos_o_r[2] <= sidex_r.pos_z;
      for (int i = 0; i < 3; i++) begin
        perp_o_r[i] <= (perp_en_r && !sidex_r.deg) ? perp_nxt[i] : '0;
      end
      deg_o_r <= perp_en_r && sidex_r.deg;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, perp_o_r[2], perp_o_r[1], perp_o_r[0],
                       pos_o_r[2], pos_o_r[1], pos_o_r[0]};
  assign out_tuser  = deg_o_r;

endmodule
